>>> design/wss_pkg.sv
// Shared types and constants for the weighted slice sum block.
// No dependencies; compiled first.
`default_nettype none

package wss_pkg;

	// Store sizes
	localparam int SLICE_COUNT    = 64;
	localparam int OUTPUT_ENTRIES = 1024;
	localparam int SLICE_AW       = $clog2(SLICE_COUNT);
	localparam int ACC_AW         = $clog2(OUTPUT_ENTRIES);

	// Field widths
	localparam int SLICE_W = 6;
	localparam int POS_W   = 10;
	localparam int VALUE_W = 16;
	localparam int PROD_W  = 2 * VALUE_W;
	localparam int ACC_W   = 40;

	// Saturation limits of the Q10.30 accumulator
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_ACC  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                     mode;
		logic [SLICE_W-1:0]        slice_index;
		logic [POS_W-1:0]          out_index;
		logic signed [VALUE_W-1:0] value;
		logic                      first;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]        out_position;
		logic signed [ACC_W-1:0] sum;
		logic                    saturated;
	} result_t;

endpackage

`default_nettype wire

>>> design/wss_item_if.sv
// Input channel of the weighted slice sum block: valid/ready plus one item.
// Depends on wss_pkg.
`default_nettype none

interface wss_item_if;
	logic           valid;
	logic           ready;
	wss_pkg::item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/wss_result_if.sv
// Output channel of the weighted slice sum block: valid/ready plus one result.
// Depends on wss_pkg.
`default_nettype none

interface wss_result_if;
	logic             valid;
	logic             ready;
	wss_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/weighted_slice_sum.sv
// Weighted slice sum: acc[out_index] (+)= weight[slice_index] * value, saturating.
// A result is registered in stage 1, stage 2 and then the output register after the transfer of its last element.
// Throughput: one item per cycle; input stalls only while the output register and
// the skid register both hold untaken results.
// Reset clears pipeline and output control only; memories are undefined until written.
// Depends on wss_pkg, wss_item_if and wss_result_if.
`default_nettype none

module weighted_slice_sum (
	input  logic         clk,
	input  logic         arst_n,
	wss_item_if.sink     item,
	wss_result_if.source result
);
	import wss_pkg::*;

	// Memories: weights, and accumulator words {saturation mark, sum}
	logic signed [VALUE_W-1:0] weight_mem [SLICE_COUNT];
	logic [ACC_W:0]            acc_mem    [OUTPUT_ENTRIES];

	logic advance;
	logic accept;
	logic slice_in_ok;
	logic pos_in_ok;

	// Stage 1: weight read data and element fields
	logic                      elem_s1;
	logic signed [VALUE_W-1:0] weight_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]          pos_s1;
	logic                      slice_ok_s1;
	logic                      first_s1;
	logic                      last_s1;
	logic signed [VALUE_W-1:0] weight_eff;

	// Stage 2: product, accumulator read data, add and saturate
	logic                     elem_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [POS_W-1:0]         pos_s2;
	logic                     first_s2;
	logic                     last_s2;
	logic [ACC_W:0]           acc_rd_s2;

	// Last write-back, forwarded to a read that raced it
	logic             wb_valid_q;
	logic [POS_W-1:0] wb_pos_q;
	logic [ACC_W:0]   wb_word_q;

	logic [ACC_W:0]          old_word;
	logic signed [ACC_W-1:0] old_acc;
	logic                    old_sat;
	logic signed [ACC_W:0]   sum_wide;
	logic signed [ACC_W-1:0] new_acc;
	logic                    new_sat;
	logic                    new_res;
	result_t                 new_data;

	// Output register and skid register
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;
	logic    out_free;

	// Handshake: the pipeline freezes only while the skid register is occupied
	assign advance     = !skid_valid_q;
	assign item.ready  = advance;
	assign accept      = item.valid && advance;
	assign slice_in_ok = 32'(item.payload.slice_index) < SLICE_COUNT;
	assign pos_in_ok   = 32'(item.payload.out_index) < OUTPUT_ENTRIES;

	// Weight memory: write on load, read for every transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			if (item.payload.mode == MODE_LOAD && slice_in_ok) begin
				weight_mem[item.payload.slice_index[SLICE_AW-1:0]] <= item.payload.value;
			end
			weight_s1 <= weight_mem[item.payload.slice_index[SLICE_AW-1:0]];
		end
	end

	// Stage 1 and 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_s1 <= 1'b0;
			elem_s2 <= 1'b0;
		end else if (advance) begin
			elem_s1 <= accept && item.payload.mode == MODE_ACC && pos_in_ok;
			elem_s2 <= elem_s1;
		end
	end

	// Stage 1 and 2 payload
	assign weight_eff = slice_ok_s1 ? weight_s1 : '0;

	always_ff @(posedge clk) begin
		if (advance) begin
			value_s1    <= item.payload.value;
			pos_s1      <= item.payload.out_index;
			slice_ok_s1 <= slice_in_ok;
			first_s1    <= item.payload.first;
			last_s1     <= item.payload.last;
			prod_s2     <= PROD_W'(value_s1) * PROD_W'(weight_eff);
			pos_s2      <= pos_s1;
			first_s2    <= first_s1;
			last_s2     <= last_s1;
		end
	end

	// Accumulator memory: read for stage 1, write back from stage 2
	always_ff @(posedge clk) begin
		if (advance) begin
			if (elem_s2) begin
				acc_mem[pos_s2[ACC_AW-1:0]] <= {new_sat, new_acc};
			end
			acc_rd_s2 <= acc_mem[pos_s1[ACC_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else if (advance) begin
			wb_valid_q <= elem_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wb_pos_q  <= pos_s2;
			wb_word_q <= {new_sat, new_acc};
		end
	end

	// Load on first, else add and saturate; the read misses a write that landed on the same edge
	always_comb begin
		old_word = (wb_valid_q && wb_pos_q == pos_s2) ? wb_word_q : acc_rd_s2;
		old_acc  = old_word[ACC_W-1:0];
		old_sat  = old_word[ACC_W];
		sum_wide = (ACC_W+1)'(old_acc) + (ACC_W+1)'(prod_s2);
		if (first_s2) begin
			new_acc = ACC_W'(prod_s2);
			new_sat = 1'b0;
		end else if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			new_acc = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
			new_sat = 1'b1;
		end else begin
			new_acc = sum_wide[ACC_W-1:0];
			new_sat = old_sat;
		end
		new_res                = elem_s2 && last_s2;
		new_data.out_position  = pos_s2;
		new_data.sum           = new_acc;
		new_data.saturated     = new_sat;
	end

	// Output register with skid stage behind it
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (result.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (new_res) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= !out_free;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (result.ready) begin
				out_data_q <= skid_data_q;
			end
		end else if (new_res) begin
			if (out_free) begin
				out_data_q <= new_data;
			end else begin
				skid_data_q <= new_data;
			end
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_data_q;

	// Checks
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !result.ready))
		else $error("skid register filled while the output register was free");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && elem_s2) |=> wb_valid_q)
		else $error("accumulator write-back not recorded for forwarding");

endmodule

`default_nettype wire
